FILE: sv/assert_macros.svh
// Assertion macros, included by the compression engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: sv/sha256_pkg.sv
// Package with SHA-256 types, constants and round functions.
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word_0;
    logic [31:0] digest_word_1;
    logic [31:0] digest_word_2;
    logic [31:0] digest_word_3;
    logic [31:0] digest_word_4;
    logic [31:0] digest_word_5;
    logic [31:0] digest_word_6;
    logic [31:0] digest_word_7;
  } out_beat_t;

  // Command from the packer to the compression engine.
  typedef enum logic [0:0] {
    CMD_BLOCK = 1'b0,
    CMD_FINAL = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e         cmd;
    logic [511:0] block;
  } job_t;

  localparam int unsigned QueueDepth = 2;

  localparam logic [255:0] InitChain = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

FILE: sv/sha256_packer.sv
// Front end: packs bytes into blocks, builds padding, issues jobs.
module sha256_packer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sha256_pkg::in_beat_t in_data_i,
  output logic                 job_valid_o,
  input  logic                 job_ready_i,
  output sha256_pkg::job_t     job_o
);

  typedef enum logic [1:0] {
    ST_FILL,
    ST_PAD,
    ST_LEN
  } state_e;

  state_e       state_q, state_d;
  logic [511:0] block_q, block_d;
  logic [63:0]  count_q, count_d;
  logic         job_valid_q, job_valid_d;
  sha256_pkg::job_t job_q, job_d;
  logic [5:0]   pos;
  logic [511:0] padded;
  logic [63:0]  bits;
  logic         slot_free;

  assign pos       = count_q[5:0];
  assign bits      = {count_q[60:0], 3'b000};
  assign slot_free = !job_valid_q || job_ready_i;
  assign in_ready_o = (state_q == ST_FILL) && slot_free;
  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

  always_comb begin
    padded = block_q;
    for (int i = 0; i < 64; i++) begin
      if (6'(i) == pos) padded[511 - 8*i -: 8] = 8'h80;
      else if (6'(i) > pos) padded[511 - 8*i -: 8] = 8'h00;
    end
  end

  always_comb begin
    state_d     = state_q;
    block_d     = block_q;
    count_d     = count_q;
    job_valid_d = job_valid_q && !job_ready_i;
    job_d       = job_q;
    case (state_q)
      ST_FILL: begin
        if (in_valid_i && in_ready_o) begin
          if (in_data_i.byte_valid) begin
            block_d[511 - 8*pos -: 8] = in_data_i.data_byte;
            count_d = count_q + 64'd1;
            if (pos == 6'd63) begin
              job_valid_d = 1'b1;
              job_d.cmd   = sha256_pkg::CMD_BLOCK;
              job_d.block = block_d;
            end
          end
          if (in_data_i.end_of_message) state_d = ST_PAD;
        end
      end
      ST_PAD: begin
        if (slot_free) begin
          job_valid_d = 1'b1;
          if (pos >= 6'd56) begin
            job_d.cmd   = sha256_pkg::CMD_BLOCK;
            job_d.block = padded;
            block_d     = '0;
            state_d     = ST_LEN;
          end else begin
            job_d.cmd   = sha256_pkg::CMD_FINAL;
            job_d.block = {padded[511:64], bits};
            count_d     = '0;
            state_d     = ST_FILL;
          end
        end
      end
      ST_LEN: begin
        if (slot_free) begin
          job_valid_d = 1'b1;
          job_d.cmd   = sha256_pkg::CMD_FINAL;
          job_d.block = {448'd0, bits};
          count_d     = '0;
          state_d     = ST_FILL;
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      count_q     <= '0;
      job_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      job_valid_q <= job_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    block_q <= block_d;
    job_q   <= job_d;
  end

endmodule

FILE: sv/sha256_queue.sv
// Two-entry job queue between packer and compression engine.
module sha256_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  sha256_pkg::job_t wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output sha256_pkg::job_t rd_data_o
);

  localparam int unsigned PtrW = $clog2(sha256_pkg::QueueDepth);

  sha256_pkg::job_t        mem_q [sha256_pkg::QueueDepth];
  logic [PtrW-1:0]         wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]           fill_q;
  logic                    push, pop;

  assign wr_ready_o = fill_q != (PtrW+1)'(sha256_pkg::QueueDepth);
  assign rd_valid_o = fill_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      fill_q <= fill_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

FILE: sv/sha256_engine.sv
// Back end: 64-round compression, one round per cycle, and digest output.
`include "assert_macros.svh"
module sha256_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  output logic                  job_ready_o,
  input  sha256_pkg::job_t      job_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sha256_pkg::out_beat_t out_data_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD
  } state_e;

  state_e         state_q;
  logic [5:0]     rnd_q;
  logic [31:0]    w_q [16];
  logic [31:0]    v_q [8];
  logic [31:0]    h_q [8];
  logic           final_q;
  logic           out_valid_q;
  sha256_pkg::out_beat_t out_q;
  logic [31:0]    t1, t2, w_new;
  logic [31:0]    hn [8];

  assign job_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign t1 = v_q[7] + sha256_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + sha256_pkg::RoundK[rnd_q] + w_q[0];
  assign t2 = sha256_pkg::bsig0(v_q[0])
            + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  assign w_new = sha256_pkg::sig1(w_q[14]) + w_q[9] + sha256_pkg::sig0(w_q[1]) + w_q[0];

  always_comb begin
    for (int i = 0; i < 8; i++) hn[i] = h_q[i] + v_q[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
      final_q     <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::InitChain[255 - 32*i -: 32];
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            for (int i = 0; i < 16; i++) w_q[i] <= job_i.block[511 - 32*i -: 32];
            for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
            final_q <= (job_i.cmd == sha256_pkg::CMD_FINAL);
            rnd_q   <= '0;
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= w_new;
          v_q[0] <= t1 + t2;
          v_q[1] <= v_q[0];
          v_q[2] <= v_q[1];
          v_q[3] <= v_q[2];
          v_q[4] <= v_q[3] + t1;
          v_q[5] <= v_q[4];
          v_q[6] <= v_q[5];
          v_q[7] <= v_q[6];
          rnd_q  <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) state_q <= ST_ADD;
        end
        ST_ADD: begin
          if (!final_q) begin
            for (int i = 0; i < 8; i++) h_q[i] <= hn[i];
            state_q <= ST_IDLE;
          end else if (!out_valid_q || out_ready_i) begin
            out_q <= {hn[0], hn[1], hn[2], hn[3], hn[4], hn[5], hn[6], hn[7]};
            out_valid_q <= 1'b1;
            for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::InitChain[255 - 32*i -: 32];
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_round_in_round, clk_i, rst_ni, rnd_q != 6'd0, state_q == ST_ROUND,
               "round counter nonzero outside rounds")
  `ASSERT_NEXT(a_last_round, clk_i, rst_ni, state_q == ST_ROUND && rnd_q == 6'd63,
               state_q == ST_ADD, "missing chain update after last round")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && !out_ready_i,
               out_valid_q && $stable(out_q), "digest dropped while stalled")

endmodule

FILE: sv/sha256_message_digest.sv
// Top level of the SHA-256 byte-stream digest block.
// Input channel: one beat per byte (in_valid_i/in_ready_o) carrying data_byte,
// byte_valid and end_of_message. Output channel: one beat per message
// (out_valid_o/out_ready_i) with the eight digest words, word 0 first.
// A byte beat is registered into the block buffer. Each full 64-byte
// block becomes a job in a two-entry queue; the compression engine runs one
// round per cycle, and each block takes a load, 64 rounds and a chain add.
// Byte intake continues while a block compresses; once the queue fills, the
// engine sets the pace for long messages.
// End of message takes one or two padding jobs (two when 56 or more bytes of
// the last block are used); the digest is registered in the chain-add step of
// the last job. Reset clears counters and loads the initial hash; no
// clearing pass is needed. A stalled output holds its digest; the engine then
// waits before finishing the next message, and the queue and packer back up
// into in_ready_o.
module sha256_message_digest (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sha256_pkg::in_beat_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sha256_pkg::out_beat_t out_data_o
);

  logic             pk_valid, pk_ready, q_valid, q_ready;
  sha256_pkg::job_t pk_job, q_job;

  sha256_packer u_packer (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .job_valid_o(pk_valid), .job_ready_i(pk_ready), .job_o(pk_job)
  );

  sha256_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(pk_valid), .wr_ready_o(pk_ready), .wr_data_i(pk_job),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_job)
  );

  sha256_engine u_engine (
    .clk_i, .rst_ni,
    .job_valid_i(q_valid), .job_ready_o(q_ready), .job_i(q_job),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
